// ===== rtl/mwm_pkg.sv =====
package mwm_pkg;

	// field widths
	localparam int STICK_W   = 16;
	localparam int GAIN_W    = 16;
	localparam int PWM_W     = 16;
	localparam int MS_W      = 15;
	localparam int TUNE_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int WHEELS    = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROT_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PWM   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PWM   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STICK = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TUNE_GAIN = 3'd4;

	// fixed-point layout
	localparam int FRAC_SH  = 8;                     // Q8.8 gain fraction
	localparam int SUM_W    = STICK_W + 1;           // y +/- x
	localparam int RT_W     = STICK_W + GAIN_W + 1;  // rot * gain
	localparam int RATIO_W  = RT_W;                  // |ratio| < 2^32
	localparam int MAG_W    = RATIO_W - 1;
	localparam int Q_W      = 16;                    // quotient 0..32768
	localparam int LO_W     = Q_W - 1;               // bits found by the divider steps
	localparam int DIV_STEPS = LO_W;
	localparam int SPAN_W   = PWM_W + 1;
	localparam int ST_W     = SPAN_W + TUNE_W + 1;   // span * tune
	localparam int MID_W    = PWM_W + 1;             // max + min
	localparam int QS_W     = Q_W + 1;
	localparam int PROD_W   = ST_W + QS_W;
	localparam int T_W      = PROD_W + 1;
	localparam int MID_SH   = 30;
	localparam int ROUND_SH = 30;
	localparam int OUT_SH   = 31;

	typedef struct packed {
		logic [GAIN_W-1:0] rot_gain;
		logic [PWM_W-1:0]  min_pwm;
		logic [PWM_W-1:0]  max_pwm;
		logic [MS_W-1:0]   max_stick;
		logic [TUNE_W-1:0] tune;
	} cfg_t;

	// per-item values needed only at the output scaling
	typedef struct packed {
		logic [ST_W-1:0]  st;    // signed span * tune
		logic [MID_W-1:0] mid2;  // max_pwm + min_pwm
	} side_t;

	typedef struct packed {
		logic [WHEELS-1:0][MAG_W-1:0] rem;
		logic [WHEELS-1:0][LO_W-1:0]  lo;
		logic [WHEELS-1:0]            hi;
		logic [WHEELS-1:0]            neg;
		logic [MAG_W-1:0]             den;
		side_t                        side;
	} div_t;

endpackage

// ===== rtl/mwm_front.sv =====
module mwm_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mwm_pkg::cfg_t                       cfg,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [mwm_pkg::STICK_W-1:0]  stick_x,
	input  logic signed [mwm_pkg::STICK_W-1:0]  stick_y,
	input  logic signed [mwm_pkg::STICK_W-1:0]  stick_rot,
	output logic                                out_valid,
	input  logic                                out_ready,
	output mwm_pkg::div_t                       out_data
);
	import mwm_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6;

	logic signed [SUM_W-1:0]  diff_c, sum_c;
	logic signed [RT_W-1:0]   rt_c;
	logic signed [SPAN_W-1:0] span_c;
	logic signed [ST_W-1:0]   st_c;
	side_t                    side_c;
	logic [MS_W-1:0]          den0_c;

	logic signed [SUM_W-1:0]   diff_s1, sum_s1;
	logic signed [RT_W-1:0]    rt_s1;
	side_t                     side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [MS_W-1:0]           den0_s1, den0_s2, den0_s3, den0_s4;
	logic signed [RATIO_W-1:0] ratio_s2 [WHEELS];
	logic signed [RATIO_W-1:0] d256, s256, rt_e;
	logic [WHEELS-1:0][MAG_W-1:0] mag_s3, mag_s4, mag_s5;
	logic [WHEELS-1:0]         neg_s3, neg_s4, neg_s5;
	logic [MAG_W-1:0]          m01_s4, m23_s4, mm_c, floor_c, den_s5;
	div_t                      out_c, out_s6;

	// stage loads when empty or when the next stage moves
	assign adv_s6   = !v_s6 || out_ready;
	assign adv_s5   = !v_s5 || adv_s6;
	assign adv_s4   = !v_s4 || adv_s5;
	assign adv_s3   = !v_s3 || adv_s4;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	assign diff_c = SUM_W'(stick_y) - SUM_W'(stick_x);
	assign sum_c  = SUM_W'(stick_y) + SUM_W'(stick_x);
	assign rt_c   = RT_W'(stick_rot) * RT_W'($signed({1'b0, cfg.rot_gain}));
	assign span_c = $signed({1'b0, cfg.max_pwm}) - $signed({1'b0, cfg.min_pwm});
	assign st_c   = ST_W'(span_c) * ST_W'($signed({1'b0, cfg.tune}));
	assign side_c.st   = st_c;
	assign side_c.mid2 = MID_W'(cfg.max_pwm) + MID_W'(cfg.min_pwm);
	assign den0_c = (cfg.max_stick == '0) ? MS_W'(1) : cfg.max_stick;

	assign d256 = RATIO_W'(diff_s1) <<< FRAC_SH;
	assign s256 = RATIO_W'(sum_s1) <<< FRAC_SH;
	assign rt_e = RATIO_W'(rt_s1);

	assign mm_c    = (m01_s4 > m23_s4) ? m01_s4 : m23_s4;
	assign floor_c = MAG_W'({den0_s4, {FRAC_SH{1'b0}}});

	always_comb begin
		for (int i = 0; i < WHEELS; i++) begin
			out_c.hi[i]  = (mag_s5[i] == den_s5);
			out_c.rem[i] = out_c.hi[i] ? '0 : mag_s5[i];
			out_c.lo[i]  = '0;
		end
		out_c.neg  = neg_s5;
		out_c.den  = den_s5;
		out_c.side = side_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
			if (adv_s5) v_s5 <= v_s4;
			if (adv_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			diff_s1 <= diff_c;
			sum_s1  <= sum_c;
			rt_s1   <= rt_c;
			side_s1 <= side_c;
			den0_s1 <= den0_c;
		end
		if (adv_s2) begin
			ratio_s2[0] <= d256 + rt_e;
			ratio_s2[1] <= s256 - rt_e;
			ratio_s2[2] <= d256 - rt_e;
			ratio_s2[3] <= s256 + rt_e;
			side_s2     <= side_s1;
			den0_s2     <= den0_s1;
		end
		if (adv_s3) begin
			for (int i = 0; i < WHEELS; i++) begin
				neg_s3[i] <= ratio_s2[i][RATIO_W-1];
				mag_s3[i] <= ratio_s2[i][RATIO_W-1] ? MAG_W'(-ratio_s2[i])
				                                    : MAG_W'(ratio_s2[i]);
			end
			side_s3 <= side_s2;
			den0_s3 <= den0_s2;
		end
		if (adv_s4) begin
			m01_s4  <= (mag_s3[0] > mag_s3[1]) ? mag_s3[0] : mag_s3[1];
			m23_s4  <= (mag_s3[2] > mag_s3[3]) ? mag_s3[2] : mag_s3[3];
			mag_s4  <= mag_s3;
			neg_s4  <= neg_s3;
			side_s4 <= side_s3;
			den0_s4 <= den0_s3;
		end
		if (adv_s5) begin
			den_s5  <= (mm_c > floor_c) ? mm_c : floor_c;
			mag_s5  <= mag_s4;
			neg_s5  <= neg_s4;
			side_s5 <= side_s4;
		end
		if (adv_s6) out_s6 <= out_c;
	end

	assign out_valid = v_s6;
	assign out_data  = out_s6;

endmodule

// ===== rtl/mwm_div_step.sv =====
module mwm_div_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mwm_pkg::div_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output mwm_pkg::div_t out_data
);
	import mwm_pkg::*;

	logic             v_s1, adv_s1;
	div_t             nxt_c, data_s1;
	logic [MAG_W:0]   rem2, den_e;
	logic             ge;

	assign adv_s1   = !v_s1 || out_ready;
	assign in_ready = adv_s1;
	assign den_e    = {1'b0, in_data.den};

	// one restoring step per lane: shift, compare, subtract
	always_comb begin
		nxt_c = in_data;
		rem2  = '0;
		ge    = 1'b0;
		for (int i = 0; i < WHEELS; i++) begin
			rem2 = {in_data.rem[i], 1'b0};
			ge   = (rem2 >= den_e);
			nxt_c.rem[i] = ge ? MAG_W'(rem2 - den_e) : MAG_W'(rem2);
			nxt_c.lo[i]  = {in_data.lo[i][LO_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) data_s1 <= nxt_c;
	end

	assign out_valid = v_s1;
	assign out_data  = data_s1;

endmodule

// ===== rtl/mwm_back.sv =====
module mwm_back (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            in_valid,
	output logic                                            in_ready,
	input  mwm_pkg::div_t                                   in_data,
	output logic                                            out_valid,
	input  logic                                            out_ready,
	output logic [mwm_pkg::WHEELS-1:0][mwm_pkg::PWM_W-1:0] pwm
);
	import mwm_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	logic signed [QS_W-1:0]   qs_s1 [WHEELS];
	logic signed [PROD_W-1:0] prod_s2 [WHEELS];
	logic signed [T_W-1:0]    t_s3 [WHEELS];
	logic signed [T_W-1:0]    mid_c;
	logic signed [T_W-1:0]    rnd_c [WHEELS];
	logic [WHEELS-1:0][PWM_W-1:0] res_c, pwm_s4;
	side_t                    side_s1, side_s2;

	assign adv_s4   = !v_s4 || out_ready;
	assign adv_s3   = !v_s3 || adv_s4;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	assign mid_c = $signed(T_W'(side_s2.mid2) << MID_SH);

	// round half up if positive, else zero; clamp overflow to all ones
	always_comb begin
		for (int i = 0; i < WHEELS; i++) begin
			rnd_c[i] = t_s3[i] + (T_W'(1) << ROUND_SH);
			if (t_s3[i][T_W-1] || t_s3[i] == '0) begin
				res_c[i] = '0;
			end else if (|rnd_c[i][T_W-1:OUT_SH+PWM_W]) begin
				res_c[i] = '1;
			end else begin
				res_c[i] = rnd_c[i][OUT_SH+PWM_W-1:OUT_SH];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			for (int i = 0; i < WHEELS; i++) begin
				qs_s1[i] <= in_data.neg[i]
				            ? -$signed(QS_W'({in_data.hi[i], in_data.lo[i]}))
				            :  $signed(QS_W'({in_data.hi[i], in_data.lo[i]}));
			end
			side_s1 <= in_data.side;
		end
		if (adv_s2) begin
			for (int i = 0; i < WHEELS; i++) begin
				prod_s2[i] <= $signed(side_s1.st) * qs_s1[i];
			end
			side_s2 <= side_s1;
		end
		if (adv_s3) begin
			for (int i = 0; i < WHEELS; i++) begin
				t_s3[i] <= T_W'(prod_s2[i]) + mid_c;
			end
		end
		if (adv_s4) pwm_s4 <= res_c;
	end

	assign out_valid = v_s4;
	assign pwm       = pwm_s4;

endmodule

// ===== rtl/mecanum_wheel_mixer.sv =====
// Mecanum wheel mixer: turns one joystick word (strafe x, forward y, rotation)
// into four wheel PWM values. Wheel ratios are y -/+ x +/- rot * rotation_gain
// (Q8.8), normalized by the largest ratio magnitude or max_stick * 256,
// whichever is larger, giving a Q1.15 quotient. Each quotient is scaled by half
// the PWM span and by tune_gain (Q1.15), offset to the PWM midpoint, rounded
// half up when positive, and saturated to 0..65535. The block is a fully
// pipelined datapath: one word is accepted every clock cycle while the output
// does not stall. A word passes six front stages (sums and product, ratio,
// magnitude, maximum, divisor, seed), the 15 restoring divider steps and four
// output stages (sign, multiply, offset, round). Stages hold under back
// pressure; empty stages fill, so input flows until every stage is full.
// Configuration is a write-only port: cfg_index selects rotation_gain (0),
// min_pwm (1), max_pwm (2), max_stick (3) or tune_gain (4); other indexes are
// ignored. Write registers only while no word is in flight. A max_stick of
// zero acts as one.
module mecanum_wheel_mixer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [mwm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mwm_pkg::CFG_DAT_W-1:0]         cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [mwm_pkg::STICK_W-1:0]    stick_x,
	input  logic signed [mwm_pkg::STICK_W-1:0]    stick_y,
	input  logic signed [mwm_pkg::STICK_W-1:0]    stick_rot,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [mwm_pkg::PWM_W-1:0]             pwm_wheel0,
	output logic [mwm_pkg::PWM_W-1:0]             pwm_wheel1,
	output logic [mwm_pkg::PWM_W-1:0]             pwm_wheel2,
	output logic [mwm_pkg::PWM_W-1:0]             pwm_wheel3
);
	import mwm_pkg::*;

	cfg_t cfg_q;

	// divider chain: index 0 is the front output, DIV_STEPS feeds the back end
	logic                 dv   [DIV_STEPS+1];
	logic                 drdy [DIV_STEPS+1];
	div_t                 dd   [DIV_STEPS+1];

	logic [WHEELS-1:0][PWM_W-1:0] pwm;

	// configuration registers: write on enable, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot_gain  <= GAIN_W'(12800);
			cfg_q.min_pwm   <= PWM_W'(499);
			cfg_q.max_pwm   <= PWM_W'(2500);
			cfg_q.max_stick <= MS_W'(32767);
			cfg_q.tune      <= TUNE_W'(16384);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROT_GAIN:  cfg_q.rot_gain  <= cfg_data[GAIN_W-1:0];
				REG_MIN_PWM:   cfg_q.min_pwm   <= cfg_data[PWM_W-1:0];
				REG_MAX_PWM:   cfg_q.max_pwm   <= cfg_data[PWM_W-1:0];
				REG_MAX_STICK: cfg_q.max_stick <= cfg_data[MS_W-1:0];
				REG_TUNE_GAIN: cfg_q.tune      <= cfg_data[TUNE_W-1:0];
				default: ;
			endcase
		end
	end

	// ratios, magnitudes, divisor and divider seed
	mwm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.stick_x   (stick_x),
		.stick_y   (stick_y),
		.stick_rot (stick_rot),
		.out_valid (dv[0]),
		.out_ready (drdy[0]),
		.out_data  (dd[0])
	);

	// one quotient bit per stage for all four wheels
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		mwm_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv[k]),
			.in_ready  (drdy[k]),
			.in_data   (dd[k]),
			.out_valid (dv[k+1]),
			.out_ready (drdy[k+1]),
			.out_data  (dd[k+1])
		);
	end

	// sign, scale, offset, round and saturate
	mwm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dv[DIV_STEPS]),
		.in_ready  (drdy[DIV_STEPS]),
		.in_data   (dd[DIV_STEPS]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pwm       (pwm)
	);

	assign pwm_wheel0 = pwm[0];
	assign pwm_wheel1 = pwm[1];
	assign pwm_wheel2 = pwm[2];
	assign pwm_wheel3 = pwm[3];

endmodule
